// File: hw/rtl/ntc_pkg.sv
// Shared types and constants for the Chinese numeral reader.
package ntc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int BCD_DIGITS = 12;

	typedef logic [VALUE_BITS-1:0]   value_t;
	typedef logic [3:0]              syl_t;
	typedef logic [4*BCD_DIGITS-1:0] bcd_t;
	typedef logic [4:0]              syl_cnt_t;
	typedef logic [4:0]              bit_cnt_t;

	localparam value_t   VALUE_LIMIT = 31'd2000000000;
	localparam syl_cnt_t MAX_SYL     = 5'd18;
	localparam bit_cnt_t LAST_BIT    = 5'(VALUE_BITS - 1);

	localparam syl_t SYL_LING = 4'd0;
	localparam syl_t SYL_SHI  = 4'd10;
	localparam syl_t SYL_BAI  = 4'd11;
	localparam syl_t SYL_QIAN = 4'd12;
	localparam syl_t SYL_WAN  = 4'd13;
	localparam syl_t SYL_YI   = 4'd14;

endpackage

// File: hw/rtl/ntc_if.sv
// Request channel interfaces: number in, syllable out.
interface ntc_num_if;
	import ntc_pkg::*;
	logic   valid;
	logic   ready;
	value_t value;
	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface ntc_syl_if;
	import ntc_pkg::*;
	logic valid;
	logic ready;
	syl_t syllable;
	logic last_syllable;
	logic out_of_range;
	modport source(output valid, output syllable, output last_syllable, output out_of_range,
		input ready);
	modport sink(input valid, input syllable, input last_syllable, input out_of_range,
		output ready);
endinterface

// File: hw/rtl/number_to_chinese_syllables.sv
// Top level of the Chinese numeral reader: integer in, syllable codes out.
//
// Usage:
//   num carries one request per integer (value, 0 to 2,000,000,000). It is
//   taken only while the block is idle, one number at a time.
//   syl carries the reading, one syllable code per request, with
//   last_syllable set on the final one. A value above the limit yields a
//   single request with out_of_range and last_syllable set.
// Timing:
//   A nonzero value in range first goes through a bit-serial binary to BCD
//   conversion, one input bit per cycle. The decimal digits are then walked
//   in three groups of four, ten slots per group, one slot per cycle while
//   syl is not stalled, and a one-deep lookahead holds each syllable until
//   the next is known so the last one can be marked. Zero and out-of-range
//   values skip the conversion and the slot walk and go straight to the
//   final flush.
// Stalls and reset:
//   A stalled syl holds the slot walk at its next emitting slot. The output
//   register lets the block take the next number while the last syllable waits.
//   arst_n clears all control state; the block comes up idle and empty.
module number_to_chinese_syllables (
	input logic       clk,
	input logic       arst_n,
	ntc_num_if.sink   num,
	ntc_syl_if.source syl
);
	import ntc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_READ, ST_FLUSH} state_t;
	typedef enum logic [3:0] {
		SL_TH, SL_QIAN, SL_LING_A, SL_H, SL_BAI, SL_LING_B, SL_T, SL_SHI, SL_U, SL_MARK
	} slot_t;
	typedef enum logic [1:0] {GRP_YI, GRP_WAN, GRP_UNIT} grp_t;

	state_t   state_q;
	slot_t    slot_q;
	grp_t     grp_q;
	value_t   bin_q;
	bcd_t     digits_q;
	bit_cnt_t bit_cnt_q;
	syl_cnt_t cnt_q;
	logic     head_q;
	logic     pend_valid_q;
	syl_t     pend_syl_q;
	logic     pend_oor_q;
	logic     out_valid_q;
	syl_t     out_syl_q;
	logic     out_last_q;
	logic     out_oor_q;

	bcd_t bcd_adj;
	bcd_t bcd_next;
	syl_t th, h, t, u;
	logic th_nz, h_nz, t_nz, u_nz, g_nz, preceded;
	logic emit;
	syl_t code;
	logic out_free;
	logic step_ok;
	logic out_load;

	assign num.ready         = (state_q == ST_IDLE);
	assign syl.valid         = out_valid_q;
	assign syl.syllable      = out_syl_q;
	assign syl.last_syllable = out_last_q;
	assign syl.out_of_range  = out_oor_q;

	// Double dabble: bump every digit of five or more by three, then shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (digits_q[4*i +: 4] > 4'd4) ?
				digits_q[4*i +: 4] + 4'd3 : digits_q[4*i +: 4];
		end
		bcd_next = {bcd_adj[4*BCD_DIGITS-2:0], bin_q[VALUE_BITS-1]};
	end

	// Current group sits in the top four digits; the walk shifts groups up.
	assign th       = digits_q[47:44];
	assign h        = digits_q[43:40];
	assign t        = digits_q[39:36];
	assign u        = digits_q[35:32];
	assign th_nz    = (th != 4'd0);
	assign h_nz     = (h != 4'd0);
	assign t_nz     = (t != 4'd0);
	assign u_nz     = (u != 4'd0);
	assign g_nz     = th_nz || h_nz || t_nz || u_nz;
	assign preceded = !head_q || th_nz;

	// Each slot either yields one syllable or is skipped.
	always_comb begin
		emit = 1'b0;
		code = SYL_LING;
		unique case (slot_q)
			SL_TH: begin
				emit = th_nz;
				code = th;
			end
			SL_QIAN: begin
				emit = th_nz;
				code = SYL_QIAN;
			end
			SL_LING_A: begin
				emit = h_nz && !th_nz && !head_q;
				code = SYL_LING;
			end
			SL_H: begin
				emit = h_nz;
				code = h;
			end
			SL_BAI: begin
				emit = h_nz;
				code = SYL_BAI;
			end
			SL_LING_B: begin
				// zero tens under a hundreds digit, or a group with no hundreds
				emit = (h_nz && !t_nz && u_nz) || (!h_nz && (t_nz || u_nz) && preceded);
				code = SYL_LING;
			end
			SL_T: begin
				// a bare leading "shi" drops its one
				emit = t_nz && (h_nz || preceded || (t > 4'd1));
				code = t;
			end
			SL_SHI: begin
				emit = t_nz;
				code = SYL_SHI;
			end
			SL_U: begin
				emit = u_nz;
				code = u;
			end
			SL_MARK: begin
				emit = g_nz && (grp_q != GRP_UNIT);
				code = (grp_q == GRP_YI) ? SYL_YI : SYL_WAN;
			end
			default: begin
				emit = 1'b0;
				code = SYL_LING;
			end
		endcase
	end

	assign out_free = !out_valid_q || syl.ready;
	assign step_ok  = !emit || !pend_valid_q || out_free;
	// a syllable moves into the output register this cycle
	assign out_load = ((state_q == ST_READ) && step_ok && emit && pend_valid_q) ||
		((state_q == ST_FLUSH) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= SL_TH;
			grp_q        <= GRP_YI;
			bin_q        <= '0;
			digits_q     <= '0;
			bit_cnt_q    <= '0;
			cnt_q        <= '0;
			head_q       <= 1'b1;
			pend_valid_q <= 1'b0;
			pend_syl_q   <= SYL_LING;
			pend_oor_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_syl_q    <= SYL_LING;
			out_last_q   <= 1'b0;
			out_oor_q    <= 1'b0;
		end else begin
			// drop the output once taken, unless a new syllable loads below
			if (out_valid_q && syl.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						if (num.value > VALUE_LIMIT || num.value == '0) begin
							pend_valid_q <= 1'b1;
							pend_syl_q   <= SYL_LING;
							pend_oor_q   <= (num.value > VALUE_LIMIT);
							state_q      <= ST_FLUSH;
						end else begin
							bin_q        <= num.value;
							digits_q     <= '0;
							bit_cnt_q    <= '0;
							cnt_q        <= '0;
							head_q       <= 1'b1;
							slot_q       <= SL_TH;
							grp_q        <= GRP_YI;
							pend_valid_q <= 1'b0;
							pend_oor_q   <= 1'b0;
							state_q      <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					digits_q  <= bcd_next;
					bin_q     <= {bin_q[VALUE_BITS-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 5'd1;
					if (bit_cnt_q == LAST_BIT) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (step_ok) begin
						if (emit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_syl_q   <= pend_syl_q;
								out_last_q  <= 1'b0;
								out_oor_q   <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_syl_q   <= code;
							cnt_q        <= cnt_q + 5'd1;
						end
						if (slot_q == SL_MARK && g_nz) begin
							head_q <= 1'b0;
						end
						// stop at the syllable cap or after the unit group
						if ((emit && cnt_q == MAX_SYL - 5'd1) ||
							(slot_q == SL_MARK && grp_q == GRP_UNIT)) begin
							state_q <= ST_FLUSH;
						end else if (slot_q == SL_MARK) begin
							slot_q   <= SL_TH;
							grp_q    <= grp_t'(grp_q + 2'd1);
							digits_q <= {digits_q[4*BCD_DIGITS-17:0], 16'h0000};
						end else begin
							slot_q <= slot_t'(slot_q + 4'd1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_syl_q    <= pend_syl_q;
						out_last_q   <= 1'b1;
						out_oor_q    <= pend_oor_q;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(num.valid && num.ready) |=> (state_q == ST_CONV || state_q == ST_FLUSH))
		else $error("accepted number did not start a reading");
	a_oor_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_oor_q) |-> out_last_q)
		else $error("out-of-range result not marked last");
	a_cnt_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_SYL)
		else $error("syllable count past cap");
	a_flush_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_valid_q)
		else $error("flush with no pending syllable");
`endif

endmodule
